/* sv/bepsq_pkg.sv */
// Shared types and constants for the burst enable pending-slot queue.
`default_nettype none

package bepsq_pkg;

  localparam int SLOT_W      = 3;
  localparam int BYTE_W      = 8;
  localparam int BITSEL_W    = 3;
  localparam int EDGE_W      = 32;
  localparam int OCC_OUT_W   = 5;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TAKE  = 1'b1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DL_BIT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_UL_BIT = CFG_INDEX_W'(1);

  // Reset values of the bit-position registers
  localparam logic [BITSEL_W-1:0] DL_BIT_RESET = BITSEL_W'(0);
  localparam logic [BITSEL_W-1:0] UL_BIT_RESET = BITSEL_W'(1);

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] tsp_byte;
    logic [SLOT_W-1:0] timeslot;
  } in_word_t;

  typedef struct packed {
    logic                 match_found;
    logic                 downlink_enable;
    logic                 uplink_enable;
    logic [EDGE_W-1:0]    rising_edge_count;
    logic [OCC_OUT_W-1:0] pending_count;
    logic                 dropped_oldest;
  } out_word_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  wdata;
  } cfg_word_t;

  // Per-cell control from the queue controller
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* sv/bepsq_if.sv */
// Valid/ready channel interfaces for input items, results and register writes.
`default_nettype none

interface bepsq_in_if import bepsq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bepsq_out_if import bepsq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bepsq_cfg_if import bepsq_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/bepsq_cell.sv */
// One queue cell: holds a timeslot, compares it to the key, loads or shifts down.
`default_nettype none

module bepsq_cell import bepsq_pkg::*; (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [SLOT_W-1:0] new_slot,
  input  wire logic [SLOT_W-1:0] upper_slot,
  input  wire logic [SLOT_W-1:0] key,
  input  wire logic              occupied,
  output logic      [SLOT_W-1:0] slot,
  output logic                   hit
);

  assign hit = occupied && (slot == key);

  // load wins over shift: on a full push the top cell takes the new word
  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      slot <= new_slot;
    end else if (ctl.shift) begin
      slot <= upper_slot;
    end else begin
      slot <= slot;
    end
  end

endmodule

`default_nettype wire

/* sv/burst_enable_pending_slot_queue.sv */
// Top level: enable pins, rising-edge counter and a row of pending-slot cells.
// The block accepts one item per clock whenever its result register is empty
// or being drained in the same cycle; an item's result is registered and appears
// in the cycle after acceptance. A push, a drop of the oldest entry and a take
// with removal all complete in the accepting cycle because every cell of the row
// compares its timeslot against the key in parallel and shifts from its newer
// neighbor. The row has QUEUE_DEPTH-1 cells, cell 0 holding the oldest entry;
// there is no clearing pass after reset. Register writes are taken in every cycle.
`default_nettype none

module burst_enable_pending_slot_queue import bepsq_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  bepsq_in_if.sink    item,
  bepsq_out_if.source result,
  bepsq_cfg_if.sink   cfg
);

  localparam int NCELL = QUEUE_DEPTH - 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH);

  logic [BITSEL_W-1:0] dl_bit;
  logic [BITSEL_W-1:0] ul_bit;
  logic                dl_pin;
  logic                ul_pin;
  logic [EDGE_W-1:0]   edge_cnt;
  logic [CNT_W-1:0]    count;

  logic [SLOT_W-1:0]   slot_q [NCELL];
  cell_ctl_t           ctl [NCELL];
  logic [NCELL-1:0]    hit;
  logic [NCELL-1:0]    occupied;
  logic [NCELL-1:0]    remove_mask;

  logic                accept;
  logic                is_take;
  logic                dl_new;
  logic                ul_new;
  logic                rise;
  logic                full;
  logic                push;
  logic                take_hit;
  logic [CNT_W-1:0]    ld_idx;
  logic [CNT_W-1:0]    count_next;
  logic [EDGE_W-1:0]   edge_next;
  logic [CNT_W+OCC_OUT_W-1:0] count_ext;

  assign item.ready = !result.valid || result.ready;
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && item.ready;

  assign is_take = (item.payload.kind == KIND_TAKE);
  assign dl_new  = item.payload.tsp_byte[dl_bit];
  assign ul_new  = item.payload.tsp_byte[ul_bit];
  assign rise    = !is_take && !dl_pin && dl_new;
  assign full    = (count == CNT_W'(NCELL));
  assign push    = accept && rise;
  assign take_hit = accept && is_take && (|hit);
  assign ld_idx  = full ? CNT_W'(NCELL - 1) : count;

  // Cells at and above the first hit take their newer neighbor's slot
  assign remove_mask = hit | ~(hit - NCELL'(1));

  always_comb begin
    for (int i = 0; i < NCELL; i++) begin
      occupied[i]  = (CNT_W'(i) < count);
      ctl[i].load  = push && (ld_idx == CNT_W'(i));
      ctl[i].shift = (push && full) || (take_hit && remove_mask[i]);
    end
  end

  always_comb begin
    priority if (push && !full) begin
      count_next = count + CNT_W'(1);
    end else if (take_hit) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  assign edge_next = push ? edge_cnt + EDGE_W'(1) : edge_cnt;
  assign count_ext = {{OCC_OUT_W{1'b0}}, count_next};

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [SLOT_W-1:0] upper;
    if (i == NCELL - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = slot_q[i+1];
    end

    bepsq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .new_slot   (item.payload.timeslot),
      .upper_slot (upper),
      .key        (item.payload.timeslot),
      .occupied   (occupied[i]),
      .slot       (slot_q[i]),
      .hit        (hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_bit       <= DL_BIT_RESET;
      ul_bit       <= UL_BIT_RESET;
      dl_pin       <= 1'b0;
      ul_pin       <= 1'b0;
      edge_cnt     <= '0;
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.payload.reg_index)
          REG_DL_BIT: dl_bit <= cfg.payload.wdata[BITSEL_W-1:0];
          REG_UL_BIT: ul_bit <= cfg.payload.wdata[BITSEL_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        if (!is_take) begin
          dl_pin <= dl_new;
          ul_pin <= ul_new;
        end
        edge_cnt     <= edge_next;
        count        <= count_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Result word: hold until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      result.payload.match_found       <= take_hit;
      result.payload.downlink_enable   <= is_take ? dl_pin : dl_new;
      result.payload.uplink_enable     <= is_take ? ul_pin : ul_new;
      result.payload.rising_edge_count <= edge_next;
      result.payload.pending_count     <= count_ext[OCC_OUT_W-1:0];
      result.payload.dropped_oldest    <= push && full;
    end
  end

endmodule

`default_nettype wire
